// ===== rtl/roikp_pkg.sv =====
package roikp_pkg;

  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_SCALE_H  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCALE_V  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MARGIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_H = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_V = 3'd4;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

endpackage

// ===== rtl/roi_from_two_keypoints.sv =====
// Region of interest from a centre keypoint and an end keypoint.
// Input channel: in_valid/in_stall carry one word holding both keypoints
// (signed Q.8 coordinates). Result channel: out_valid/out_stall carry one
// word with the box origin and size (clamped at zero), the centre passed
// through, the reach point and the zero_distance flag.
// The pipeline has one register stage per root bit of the square root, one per
// quotient bit of the reach division, and others for the differences, squares,
// radius, scaling, box sums, overflow check and reach point.
// Throughput is one word per cycle while out_stall is low; every stage holds
// a valid bit and a stage moves on whenever the stage after it is empty or
// moving, so empty slots are squeezed out and words are accepted while a
// result waits. When out_stall is held the last stage keeps its word, and
// the stages behind it fill up before in_stall is raised.
// Registers sit on an APB-style port (4 bytes apart, pready always high)
// and should only be written while the pipeline is empty. Reset empties
// the pipeline and loads scales of 1.0 and zero margin and offsets.
module roi_from_two_keypoints #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [roikp_pkg::ADDR_W-1:0]    paddr,
  input  logic [roikp_pkg::DATA_W-1:0]    pwdata,
  output logic [roikp_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_center_x,
  input  logic signed [COORD_WIDTH-1:0]   in_center_y,
  input  logic signed [COORD_WIDTH-1:0]   in_tip_x,
  input  logic signed [COORD_WIDTH-1:0]   in_tip_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [COORD_WIDTH-2:0]          out_box_x,
  output logic [COORD_WIDTH-2:0]          out_box_y,
  output logic [COORD_WIDTH-2:0]          out_box_width,
  output logic [COORD_WIDTH-2:0]          out_box_height,
  output logic signed [COORD_WIDTH-1:0]   out_center_x,
  output logic signed [COORD_WIDTH-1:0]   out_center_y,
  output logic signed [COORD_WIDTH-1:0]   out_reach_x,
  output logic signed [COORD_WIDTH-1:0]   out_reach_y,
  output logic                            out_zero_distance
);
  import roikp_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NR  = W + 1;
  localparam int QB  = W + 2;
  localparam int NW  = 2 * W + 7;
  localparam int SQ0 = 2;
  localparam int SC  = SQ0 + NR;
  localparam int SD  = SC + 4;
  localparam int SF  = SD + QB + 1;
  localparam int NS  = SF + 1;

  typedef struct packed {
    logic signed [W-1:0]    cx;
    logic signed [W-1:0]    cy;
    logic                   dxn;
    logic                   dyn;
    logic [W:0]             ax;
    logic [W:0]             ay;
    logic [2*W+1:0]         sq;
    logic [W+2:0]           rem;
    logic [W:0]             root;
    logic signed [W+2:0]    radius;
    logic signed [W+19:0]   pw;
    logic signed [W+19:0]   ph;
    logic signed [W+6:0]    hw;
    logic signed [W+6:0]    hh;
    logic [W+5:0]           hax;
    logic [W+5:0]           hay;
    logic [NW-1:0]          rx;
    logic [NW-1:0]          ry;
    logic [QB-1:0]          qx;
    logic [QB-1:0]          qy;
    logic                   ovx;
    logic                   ovy;
    logic [W-2:0]           bx;
    logic [W-2:0]           by;
    logic [W-2:0]           bwd;
    logic [W-2:0]           bht;
    logic signed [W-1:0]    rcx;
    logic signed [W-1:0]    rcy;
  } pl_t;

  // Configuration registers.
  logic [SCALE_W-1:0]  sh_r, sv_r;
  logic signed [W-1:0] margin_r, offh_r, offv_r;
  logic [IDX_W-1:0]    idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r     <= SCALE_ONE;
      sv_r     <= SCALE_ONE;
      margin_r <= '0;
      offh_r   <= '0;
      offv_r   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SCALE_H:  sh_r     <= pwdata[SCALE_W-1:0];
        REG_SCALE_V:  sv_r     <= pwdata[SCALE_W-1:0];
        REG_MARGIN:   margin_r <= pwdata[W-1:0];
        REG_OFFSET_H: offh_r   <= pwdata[W-1:0];
        REG_OFFSET_V: offv_r   <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCALE_H:  prdata = DATA_W'(sh_r);
      REG_SCALE_V:  prdata = DATA_W'(sv_r);
      REG_MARGIN:   prdata = DATA_W'($unsigned(margin_r));
      REG_OFFSET_H: prdata = DATA_W'($unsigned(offh_r));
      REG_OFFSET_V: prdata = DATA_W'($unsigned(offv_r));
      default:      prdata = '0;
    endcase
  end

  function automatic logic [W-2:0] sat_box(input logic signed [W+7:0] v);
    logic signed [W+7:0] hi;
    hi = $signed({9'b0, {(W-1){1'b1}}});
    if (v < 0) begin
      return '0;
    end else if (v > hi) begin
      return {(W-1){1'b1}};
    end else begin
      return v[W-2:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat_coord(input logic signed [W+2:0] v);
    logic signed [W+2:0] hi, lo;
    hi = $signed({4'b0000, {(W-1){1'b1}}});
    lo = $signed({4'b1111, {(W-1){1'b0}}});
    if (v > hi) begin
      return hi[W-1:0];
    end else if (v < lo) begin
      return lo[W-1:0];
    end else begin
      return v[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] reach(input logic signed [W-1:0] c,
                                                input logic neg, input logic ov,
                                                input logic [QB-1:0] q,
                                                input logic [W:0] span);
    logic [QB-1:0]       cap, t;
    logic signed [W+2:0] ce, te;
    cap = QB'(1) << (W + 1);
    t   = (ov || q > cap) ? cap : q;
    ce  = (W+3)'(c);
    te  = $signed({1'b0, t});
    if (span == '0) begin
      return c;
    end else begin
      return sat_coord(neg ? ce - te : ce + te);
    end
  endfunction

  // Pipeline.
  pl_t          s_r   [NS];
  pl_t          s_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  assign rdy[NS] = !out_stall;
  genvar gk;
  generate
    for (gk = 0; gk < NS; gk++) begin : g_ctl
      assign rdy[gk] = !v_r[gk] || rdy[gk+1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gk] <= 1'b0;
        end else if (rdy[gk]) begin
          v_r[gk] <= (gk == 0) ? in_valid : v_r[(gk == 0) ? 0 : gk-1];
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[gk]) begin
          s_r[gk] <= s_nxt[gk];
        end
      end
    end

    for (gk = 0; gk < NS; gk++) begin : g_stage
      if (gk == 0) begin : g_diff
        always_comb begin
          logic signed [W:0] dx, dy;
          s_nxt[gk]    = '0;
          dx           = (W+1)'(in_tip_x) - (W+1)'(in_center_x);
          dy           = (W+1)'(in_tip_y) - (W+1)'(in_center_y);
          s_nxt[gk].cx  = in_center_x;
          s_nxt[gk].cy  = in_center_y;
          s_nxt[gk].dxn = dx[W];
          s_nxt[gk].dyn = dy[W];
          s_nxt[gk].ax  = dx[W] ? $unsigned(-dx) : $unsigned(dx);
          s_nxt[gk].ay  = dy[W] ? $unsigned(-dy) : $unsigned(dy);
        end
      end else if (gk == 1) begin : g_square
        always_comb begin
          logic [2*W+1:0] px, py;
          s_nxt[gk]      = s_r[gk-1];
          px             = (2*W+2)'(s_r[gk-1].ax) * (2*W+2)'(s_r[gk-1].ax);
          py             = (2*W+2)'(s_r[gk-1].ay) * (2*W+2)'(s_r[gk-1].ay);
          s_nxt[gk].sq   = px + py;
          s_nxt[gk].rem  = '0;
          s_nxt[gk].root = '0;
        end
      end else if (gk < SC) begin : g_root
        // One root bit per stage, taking two bits of the sum from the top.
        localparam int PI = NR - 1 - (gk - SQ0);
        always_comb begin
          logic [W+4:0] remw, trial;
          s_nxt[gk] = s_r[gk-1];
          remw      = {s_r[gk-1].rem, s_r[gk-1].sq[2*PI +: 2]};
          trial     = {2'b00, s_r[gk-1].root, 2'b01};
          if (remw >= trial) begin
            s_nxt[gk].rem  = (W+3)'(remw - trial);
            s_nxt[gk].root = {s_r[gk-1].root[W-1:0], 1'b1};
          end else begin
            s_nxt[gk].rem  = remw[W+2:0];
            s_nxt[gk].root = {s_r[gk-1].root[W-1:0], 1'b0};
          end
        end
      end else if (gk == SC) begin : g_radius
        always_comb begin
          s_nxt[gk]        = s_r[gk-1];
          s_nxt[gk].radius = $signed({2'b00, s_r[gk-1].root}) + (W+3)'(margin_r);
        end
      end else if (gk == SC + 1) begin : g_scale
        always_comb begin
          s_nxt[gk]    = s_r[gk-1];
          s_nxt[gk].pw = s_r[gk-1].radius * $signed({1'b0, sh_r});
          s_nxt[gk].ph = s_r[gk-1].radius * $signed({1'b0, sv_r});
        end
      end else if (gk == SC + 2) begin : g_half
        // Drop the scale fraction, rounding toward zero.
        always_comb begin
          logic signed [W+19:0] tw, th;
          logic signed [W+6:0]  hw, hh;
          s_nxt[gk] = s_r[gk-1];
          tw = s_r[gk-1].pw[W+19] ? (s_r[gk-1].pw + (W+20)'(4095)) >>> SCALE_FRAC
                                  : s_r[gk-1].pw >>> SCALE_FRAC;
          th = s_r[gk-1].ph[W+19] ? (s_r[gk-1].ph + (W+20)'(4095)) >>> SCALE_FRAC
                                  : s_r[gk-1].ph >>> SCALE_FRAC;
          hw = tw[W+6:0];
          hh = th[W+6:0];
          s_nxt[gk].hw  = hw;
          s_nxt[gk].hh  = hh;
          s_nxt[gk].hax = hw[W+6] ? (W+6)'($unsigned(-hw)) : hw[W+5:0];
          s_nxt[gk].hay = hh[W+6] ? (W+6)'($unsigned(-hh)) : hh[W+5:0];
        end
      end else if (gk == SC + 3) begin : g_box
        always_comb begin
          logic signed [W+7:0] hwe, hhe;
          s_nxt[gk]     = s_r[gk-1];
          hwe           = (W+8)'(s_r[gk-1].hw);
          hhe           = (W+8)'(s_r[gk-1].hh);
          s_nxt[gk].bx  = sat_box((W+8)'(s_r[gk-1].cx) - hwe + (W+8)'(offh_r));
          s_nxt[gk].by  = sat_box((W+8)'(s_r[gk-1].cy) - hhe + (W+8)'(offv_r));
          s_nxt[gk].bwd = sat_box(hwe <<< 1);
          s_nxt[gk].bht = sat_box(hhe <<< 1);
          s_nxt[gk].rx  = NW'(s_r[gk-1].ax) * NW'(s_r[gk-1].hax);
          s_nxt[gk].ry  = NW'(s_r[gk-1].ay) * NW'(s_r[gk-1].hay);
        end
      end else if (gk == SD) begin : g_over
        // A quotient beyond the top bit is certainly over the cap.
        always_comb begin
          logic [NW:0] dtop;
          s_nxt[gk]     = s_r[gk-1];
          dtop          = (NW+1)'(s_r[gk-1].root) << QB;
          s_nxt[gk].ovx = {1'b0, s_r[gk-1].rx} >= dtop;
          s_nxt[gk].ovy = {1'b0, s_r[gk-1].ry} >= dtop;
          s_nxt[gk].qx  = '0;
          s_nxt[gk].qy  = '0;
        end
      end else if (gk < SF) begin : g_div
        localparam int J = QB - 1 - (gk - SD - 1);
        always_comb begin
          logic [NW-1:0] dsh;
          s_nxt[gk] = s_r[gk-1];
          dsh       = NW'(s_r[gk-1].root) << J;
          if (s_r[gk-1].rx >= dsh) begin
            s_nxt[gk].rx    = s_r[gk-1].rx - dsh;
            s_nxt[gk].qx[J] = 1'b1;
          end
          if (s_r[gk-1].ry >= dsh) begin
            s_nxt[gk].ry    = s_r[gk-1].ry - dsh;
            s_nxt[gk].qy[J] = 1'b1;
          end
        end
      end else begin : g_reach
        always_comb begin
          s_nxt[gk]     = s_r[gk-1];
          s_nxt[gk].rcx = reach(s_r[gk-1].cx, s_r[gk-1].dxn ^ s_r[gk-1].hw[W+6],
                                s_r[gk-1].ovx, s_r[gk-1].qx, s_r[gk-1].root);
          s_nxt[gk].rcy = reach(s_r[gk-1].cy, s_r[gk-1].dyn ^ s_r[gk-1].hh[W+6],
                                s_r[gk-1].ovy, s_r[gk-1].qy, s_r[gk-1].root);
        end
      end
    end
  endgenerate

  assign in_stall          = !rdy[0];
  assign out_valid         = v_r[NS-1];
  assign out_box_x         = s_r[NS-1].bx;
  assign out_box_y         = s_r[NS-1].by;
  assign out_box_width     = s_r[NS-1].bwd;
  assign out_box_height    = s_r[NS-1].bht;
  assign out_center_x      = s_r[NS-1].cx;
  assign out_center_y      = s_r[NS-1].cy;
  assign out_reach_x       = s_r[NS-1].rcx;
  assign out_reach_y       = s_r[NS-1].rcy;
  assign out_zero_distance = (s_r[NS-1].root == '0);

endmodule
